// ----- rtl/mfa_pkg.sv -----
// Metaball field accumulator: shared types, constants and codes.
// Used by the top level, the divider and the bench; depends on nothing.
`timescale 1ns / 1ps

package mfa_pkg;

  // Grid size and derived widths
  localparam int GRID_VERTICES = 4096;
  localparam int ADDR_W        = $clog2(GRID_VERTICES);
  localparam int CNT_W         = $clog2(GRID_VERTICES + 1);

  // Divider widths: dividend up to |offset|*r2*4096, divisor is d2
  localparam int DIV_W  = 60;
  localparam int D2_W   = 34;
  localparam int DCNT_W = $clog2(DIV_W);

  // Register reset values
  localparam logic [31:0] THRESHOLD_RESET = 32'd1966;
  localparam logic [12:0] COUNT_RESET     = 13'd4096;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_COUNT     = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ADD   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_OFF,
    ST_MUL,
    ST_SUM,
    ST_DSTART,
    ST_DWAIT,
    ST_WB
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [11:0]        vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [31:0]        radius_sq;
  } item_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic [31:0]        field_value;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } result_t;

  // One entry of the field memory
  typedef struct packed {
    logic [31:0]        value;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
  } field_word_t;

  // One entry of the position memory: z, y, x
  typedef struct packed {
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } pos_word_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [D2_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/metaball_field_accumulator_top.sv -----
// Metaball field accumulator top level: sequencer, datapath, memories.
// Depends on mfa_pkg, mfa_ram and mfa_div.
`timescale 1ns / 1ps

// Items are taken when start is high and busy is low. Busy stays low after
// a write item. For a read item the result appears on result_o with
// result_valid_o high for exactly one cycle, the cycle after the item is
// taken, and must be captured then. A clear item writes one field-memory
// entry per cycle over all GRID_VERTICES entries; the same pass runs after
// reset, so busy is high after reset until that pass is done.
// An add-ball item visits each vertex in use in turn: seven divisions on one
// shared bit-serial divider plus the memory read, the offset, multiply and
// sum stages and the write-back. Vertices whose squared distance is zero
// skip the divisions and the write-back. Configuration writes are
// always ready and are meant to be made while busy is low.
module metaball_field_accumulator_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mfa_pkg::item_t   in_item_i,
  output logic             result_valid_o,
  output mfa_pkg::result_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  mfa_pkg::state_e state_q, state_d;

  logic [31:0]                thr_q;
  logic [12:0]                count_q;
  logic [mfa_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic [mfa_pkg::CNT_W-1:0]  j_q, j_d;
  logic [mfa_pkg::CNT_W-1:0]  n_q, n_d;
  logic [2:0]                 step_q, step_d;

  logic [11:0]                idx_q;
  logic                       oor_q;
  logic signed [15:0]         bx_q, by_q, bz_q;
  logic [31:0]                r2_q;
  mfa_pkg::field_word_t       fw_q;
  logic [15:0]                ab_q [3];
  logic                       neg_q [3];
  logic [31:0]                sq_q [3];
  logic [47:0]                prod_q [3];
  logic [mfa_pkg::D2_W-1:0]   d2_q;
  logic [mfa_pkg::D2_W-1:0]   d2_sum;
  logic [31:0]                inc_q;
  logic [mfa_pkg::DIV_W-1:0]  q1_q;
  logic [32:0]                mag_q [3];

  logic                       accept;
  logic                       idx_ok;
  logic                       last_vertex;
  logic [1:0]                 axis;

  // Memory ports
  logic                       pos_we;
  logic [mfa_pkg::ADDR_W-1:0] pos_waddr, rd_addr;
  mfa_pkg::pos_word_t         pos_wdata, pos_rdata;
  logic                       fld_we;
  logic [mfa_pkg::ADDR_W-1:0] fld_waddr;
  mfa_pkg::field_word_t       fld_wdata, fld_rdata, fw_new;

  mfa_pkg::div_req_t          div_req;
  mfa_pkg::div_rsp_t          div_rsp;

  assign accept      = start && !busy;
  assign idx_ok      = 32'(in_item_i.vertex_index) < mfa_pkg::GRID_VERTICES;
  assign last_vertex = (j_q + 1'b1) == n_q;
  assign axis        = 2'((step_q - 3'd1) >> 1);

  // d2 is summed from the squares in the SUM stage
  assign d2_sum = mfa_pkg::D2_W'(sq_q[0]) + mfa_pkg::D2_W'(sq_q[1]) + mfa_pkg::D2_W'(sq_q[2]);

  // Offset and magnitude of one coordinate
  function automatic logic [16:0] offset(logic [15:0] p, logic signed [15:0] b);
    offset = 17'($signed({p[15], p}) - $signed({b[15], b}));
  endfunction

  function automatic logic [15:0] absval(logic [16:0] d);
    absval = d[16] ? 16'(-d) : d[15:0];
  endfunction

  // Saturating signed accumulate of a signed magnitude
  function automatic logic [31:0] nsat(logic [31:0] acc, logic [32:0] mag, logic neg);
    logic signed [34:0] s;
    s = $signed({{3{acc[31]}}, acc}) + (neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
    if (s > 35'sd2147483647) begin
      nsat = 32'h7FFF_FFFF;
    end else if (s < -35'sd2147483648) begin
      nsat = 32'h8000_0000;
    end else begin
      nsat = s[31:0];
    end
  endfunction

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mfa_pkg::ST_CLEAR: begin
        if (clr_q == mfa_pkg::ADDR_W'(mfa_pkg::GRID_VERTICES - 1)) state_d = mfa_pkg::ST_IDLE;
      end
      mfa_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_item_i.op)
            mfa_pkg::OP_CLEAR: state_d = mfa_pkg::ST_CLEAR;
            mfa_pkg::OP_READ:  state_d = mfa_pkg::ST_READ;
            mfa_pkg::OP_ADD:   state_d = (n_d != '0) ? mfa_pkg::ST_FETCH : mfa_pkg::ST_IDLE;
            default:           state_d = mfa_pkg::ST_IDLE;
          endcase
        end
      end
      mfa_pkg::ST_READ:   state_d = mfa_pkg::ST_IDLE;
      mfa_pkg::ST_FETCH:  state_d = mfa_pkg::ST_OFF;
      mfa_pkg::ST_OFF:    state_d = mfa_pkg::ST_MUL;
      mfa_pkg::ST_MUL:    state_d = mfa_pkg::ST_SUM;
      mfa_pkg::ST_SUM: begin
        if (d2_sum != '0) begin
          state_d = mfa_pkg::ST_DSTART;
        end else begin
          state_d = last_vertex ? mfa_pkg::ST_IDLE : mfa_pkg::ST_FETCH;
        end
      end
      mfa_pkg::ST_DSTART: state_d = mfa_pkg::ST_DWAIT;
      mfa_pkg::ST_DWAIT: begin
        if (div_rsp.done) state_d = (step_q == 3'd6) ? mfa_pkg::ST_WB : mfa_pkg::ST_DSTART;
      end
      mfa_pkg::ST_WB:     state_d = last_vertex ? mfa_pkg::ST_IDLE : mfa_pkg::ST_FETCH;
      default:            state_d = mfa_pkg::ST_IDLE;
    endcase
  end

  // Counters
  always_comb begin
    clr_d  = (state_q == mfa_pkg::ST_CLEAR) ? clr_q + 1'b1 : '0;
    n_d    = n_q;
    j_d    = j_q;
    step_d = step_q;
    if (state_q == mfa_pkg::ST_IDLE) begin
      j_d = '0;
      n_d = (32'(count_q) > mfa_pkg::GRID_VERTICES) ?
            mfa_pkg::CNT_W'(mfa_pkg::GRID_VERTICES) : mfa_pkg::CNT_W'(count_q);
      if (!(accept && in_item_i.op == mfa_pkg::OP_ADD)) n_d = n_q;
    end
    if (state_q == mfa_pkg::ST_WB ||
        (state_q == mfa_pkg::ST_SUM && d2_sum == '0)) begin
      j_d = j_q + 1'b1;
    end
    if (state_q == mfa_pkg::ST_SUM) step_d = '0;
    if (state_q == mfa_pkg::ST_DWAIT && div_rsp.done) step_d = step_q + 3'd1;
  end

  // Outputs, memory controls and divider request
  always_comb begin
    busy           = state_q != mfa_pkg::ST_IDLE;
    cfg_ready_o    = 1'b1;
    result_valid_o = state_q == mfa_pkg::ST_READ;
    result_o.out_index   = idx_q;
    result_o.field_value = oor_q ? '0 : fld_rdata.value;
    result_o.normal_x    = oor_q ? '0 : fld_rdata.nx;
    result_o.normal_y    = oor_q ? '0 : fld_rdata.ny;
    result_o.normal_z    = oor_q ? '0 : fld_rdata.nz;

    rd_addr   = (state_q == mfa_pkg::ST_IDLE) ?
                mfa_pkg::ADDR_W'(in_item_i.vertex_index) : j_q[mfa_pkg::ADDR_W-1:0];
    pos_we    = accept && in_item_i.op == mfa_pkg::OP_WRITE && idx_ok;
    pos_waddr = mfa_pkg::ADDR_W'(in_item_i.vertex_index);
    pos_wdata = {in_item_i.pos_z, in_item_i.pos_y, in_item_i.pos_x};

    fw_new.value = fw_q.value;
    if (inc_q > thr_q) begin
      fw_new.value = ({1'b0, fw_q.value} + {1'b0, inc_q} > 33'h0_FFFF_FFFF) ?
                     32'hFFFF_FFFF : fw_q.value + inc_q;
    end
    fw_new.nx = nsat(fw_q.nx, mag_q[0], neg_q[0]);
    fw_new.ny = nsat(fw_q.ny, mag_q[1], neg_q[1]);
    fw_new.nz = nsat(fw_q.nz, mag_q[2], neg_q[2]);

    fld_we    = state_q == mfa_pkg::ST_CLEAR || state_q == mfa_pkg::ST_WB;
    fld_waddr = (state_q == mfa_pkg::ST_CLEAR) ? clr_q : j_q[mfa_pkg::ADDR_W-1:0];
    fld_wdata = (state_q == mfa_pkg::ST_CLEAR) ? '0 : fw_new;

    div_req.start   = state_q == mfa_pkg::ST_DSTART;
    div_req.divisor = d2_q;
    if (step_q == 3'd0) begin
      div_req.dividend = mfa_pkg::DIV_W'({r2_q, 8'h00});
    end else if (step_q[0]) begin
      div_req.dividend = {prod_q[axis], 12'h000};
    end else begin
      div_req.dividend = q1_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfa_pkg::ST_CLEAR;
      clr_q   <= '0;
      j_q     <= '0;
      n_q     <= '0;
      step_q  <= '0;
      thr_q   <= mfa_pkg::THRESHOLD_RESET;
      count_q <= mfa_pkg::COUNT_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      j_q     <= j_d;
      n_q     <= n_d;
      step_q  <= step_d;
      if (cfg_valid_i && cfg_index_i == mfa_pkg::CFG_THRESHOLD) thr_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == mfa_pkg::CFG_COUNT) count_q <= cfg_data_i[12:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= in_item_i.vertex_index;
      oor_q <= !idx_ok;
      bx_q  <= in_item_i.pos_x;
      by_q  <= in_item_i.pos_y;
      bz_q  <= in_item_i.pos_z;
      r2_q  <= in_item_i.radius_sq;
    end
    // offsets from the ball, split into sign and magnitude
    if (state_q == mfa_pkg::ST_OFF) begin
      fw_q      <= fld_rdata;
      ab_q[0]   <= absval(offset(pos_rdata.x, bx_q));
      ab_q[1]   <= absval(offset(pos_rdata.y, by_q));
      ab_q[2]   <= absval(offset(pos_rdata.z, bz_q));
      neg_q[0]  <= offset(pos_rdata.x, bx_q) >> 16 != 17'd0;
      neg_q[1]  <= offset(pos_rdata.y, by_q) >> 16 != 17'd0;
      neg_q[2]  <= offset(pos_rdata.z, bz_q) >> 16 != 17'd0;
    end
    // squares and numerator products
    if (state_q == mfa_pkg::ST_MUL) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a]   <= ab_q[a] * ab_q[a];
        prod_q[a] <= ab_q[a] * r2_q;
      end
    end
    if (state_q == mfa_pkg::ST_SUM) begin
      d2_q <= d2_sum;
    end
    // divider results: value term, then two passes per axis
    if (state_q == mfa_pkg::ST_DWAIT && div_rsp.done) begin
      if (step_q == 3'd0) begin
        inc_q <= (div_rsp.quotient[mfa_pkg::DIV_W-1:32] != '0) ?
                 32'hFFFF_FFFF : div_rsp.quotient[31:0];
      end else if (step_q[0]) begin
        q1_q <= div_rsp.quotient;
      end else begin
        mag_q[axis] <= (div_rsp.quotient > mfa_pkg::DIV_W'(33'h1_0000_0000)) ?
                       33'h1_0000_0000 : div_rsp.quotient[32:0];
      end
    end
  end

  mfa_ram #(
    .Width ($bits(mfa_pkg::pos_word_t)),
    .Depth (mfa_pkg::GRID_VERTICES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (rd_addr),
    .rdata_o (pos_rdata)
  );

  mfa_ram #(
    .Width ($bits(mfa_pkg::field_word_t)),
    .Depth (mfa_pkg::GRID_VERTICES)
  ) u_fld_ram (
    .clk_i   (clk_i),
    .we_i    (fld_we),
    .waddr_i (fld_waddr),
    .wdata_i (fld_wdata),
    .raddr_i (rd_addr),
    .rdata_o (fld_rdata)
  );

  mfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`ifndef SYNTHESIS
  // A read result is a single-cycle strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // The divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == mfa_pkg::ST_DWAIT)
    else $error("divider done outside wait state");

  // The walk never runs past the vertex count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mfa_pkg::ST_FETCH |-> j_q < n_q)
    else $error("walk index beyond vertex count");

  // Field memory is written only by the clearing pass or the write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_we |-> busy && !result_valid_o)
    else $error("field write while idle or reading");
`endif

endmodule

// ----- rtl/mfa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module mfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/mfa_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on mfa_pkg for widths and request/response types.
`timescale 1ns / 1ps

module mfa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfa_pkg::div_req_t req_i,
  output mfa_pkg::div_rsp_t rsp_o
);

  logic                         run_q, run_d;
  logic                         done_q, done_d;
  logic [mfa_pkg::DCNT_W-1:0]   cnt_q, cnt_d;
  logic [mfa_pkg::DIV_W-1:0]    dvd_q, dvd_d;
  logic [mfa_pkg::D2_W-1:0]     rem_q, rem_d;
  logic [mfa_pkg::D2_W-1:0]     dsr_q, dsr_d;
  logic [mfa_pkg::D2_W:0]       trial;
  logic                         fits;

  // Shift in one dividend bit, subtract when it fits
  assign trial = {rem_q, dvd_q[mfa_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = req_i.dividend;
      rem_d = '0;
      dsr_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = fits ? mfa_pkg::D2_W'(trial - {1'b0, dsr_q}) : trial[mfa_pkg::D2_W-1:0];
      dvd_d = {dvd_q[mfa_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mfa_pkg::DCNT_W'(mfa_pkg::DIV_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the metaball field accumulator: directed table,
// then random phases under several register settings. Depends on mfa_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SMALL_SET    = 16;

  typedef struct {
    mfa_pkg::item_t   itm;
    bit               typed;
    mfa_pkg::result_t res;
  } row_t;

  logic             clk_i, rst_ni;
  logic             start, busy;
  mfa_pkg::item_t   in_item_i;
  logic             result_valid_o;
  mfa_pkg::result_t result_o;
  logic             cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0]      cfg_data_i;

  // Shadow copy of the block state
  logic [15:0] px_mem [mfa_pkg::GRID_VERTICES];
  logic [15:0] py_mem [mfa_pkg::GRID_VERTICES];
  logic [15:0] pz_mem [mfa_pkg::GRID_VERTICES];
  bit          pos_known [mfa_pkg::GRID_VERTICES];
  logic [31:0] fv_mem [mfa_pkg::GRID_VERTICES];
  logic [31:0] nx_mem [mfa_pkg::GRID_VERTICES];
  logic [31:0] ny_mem [mfa_pkg::GRID_VERTICES];
  logic [31:0] nz_mem [mfa_pkg::GRID_VERTICES];
  logic [31:0] thr_reg;
  logic [12:0] cnt_reg;

  mfa_pkg::result_t pending_reads [$];
  row_t             dir_rows [$];
  int               errors = 0;
  int               cycles = 0;
  bit               allow_idle;

  metaball_field_accumulator_top u_dut (
    .clk_i, .rst_ni, .start, .busy, .in_item_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    mfa_pkg::result_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result, index %0d", result_o.out_index);
        errors++;
      end else begin
        e = pending_reads.pop_front();
        if (result_o.out_index !== e.out_index) begin
          $error("out_index exp %h got %h", e.out_index, result_o.out_index); errors++;
        end
        if (result_o.field_value !== e.field_value) begin
          $error("field_value exp %h got %h", e.field_value, result_o.field_value); errors++;
        end
        if (result_o.normal_x !== e.normal_x) begin
          $error("normal_x exp %h got %h", e.normal_x, result_o.normal_x); errors++;
        end
        if (result_o.normal_y !== e.normal_y) begin
          $error("normal_y exp %h got %h", e.normal_y, result_o.normal_y); errors++;
        end
        if (result_o.normal_z !== e.normal_z) begin
          $error("normal_z exp %h got %h", e.normal_z, result_o.normal_z); errors++;
        end
      end
    end
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // Saturating add of one normal term
  function automatic logic [31:0] normal_acc(logic [31:0] acc, longint off,
                                             longint unsigned r2, longint unsigned d2);
    longint unsigned m;
    longint          s;
    m = (((off < 0) ? longint'(-off) : off) * r2) << 12;
    m = m / d2 / d2;
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    s = longint'($signed(acc)) + ((off < 0) ? -longint'(m) : longint'(m));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  // Field accumulation for one ball over the vertices in use
  task automatic accumulate_ball(mfa_pkg::item_t it);
    int              n;
    longint          dx, dy, dz;
    longint unsigned d2, inc, r2, sum;
    n  = (int'(cnt_reg) > mfa_pkg::GRID_VERTICES) ? mfa_pkg::GRID_VERTICES : int'(cnt_reg);
    r2 = 64'(it.radius_sq);
    for (int j = 0; j < n; j++) begin
      dx = sx16(px_mem[j]) - sx16(it.pos_x);
      dy = sx16(py_mem[j]) - sx16(it.pos_y);
      dz = sx16(pz_mem[j]) - sx16(it.pos_z);
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 == 0) continue;
      inc = (r2 << 8) / d2;
      if (inc > 64'hFFFF_FFFF) inc = 64'hFFFF_FFFF;
      if (inc > 64'(thr_reg)) begin
        sum = 64'(fv_mem[j]) + inc;
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        fv_mem[j] = sum[31:0];
      end
      nx_mem[j] = normal_acc(nx_mem[j], dx, r2, d2);
      ny_mem[j] = normal_acc(ny_mem[j], dy, r2, d2);
      nz_mem[j] = normal_acc(nz_mem[j], dz, r2, d2);
    end
  endtask

  task automatic clear_shadow();
    for (int j = 0; j < mfa_pkg::GRID_VERTICES; j++) begin
      fv_mem[j] = '0; nx_mem[j] = '0; ny_mem[j] = '0; nz_mem[j] = '0;
    end
  endtask

  // Update the shadow for one accepted item; returns read data
  task automatic apply_item(mfa_pkg::item_t it, output mfa_pkg::result_t r);
    r = '0;
    case (mfa_pkg::op_e'(it.op))
      mfa_pkg::OP_WRITE: begin
        px_mem[it.vertex_index] = it.pos_x;
        py_mem[it.vertex_index] = it.pos_y;
        pz_mem[it.vertex_index] = it.pos_z;
        pos_known[it.vertex_index] = 1'b1;
      end
      mfa_pkg::OP_CLEAR: clear_shadow();
      mfa_pkg::OP_ADD:   accumulate_ball(it);
      mfa_pkg::OP_READ: begin
        r.out_index   = it.vertex_index;
        r.field_value = fv_mem[it.vertex_index];
        r.normal_x    = nx_mem[it.vertex_index];
        r.normal_y    = ny_mem[it.vertex_index];
        r.normal_z    = nz_mem[it.vertex_index];
      end
      default: ;
    endcase
  endtask

  // Present one item and hold it until taken
  task automatic issue_item(mfa_pkg::item_t it, bit typed, mfa_pkg::result_t typed_res);
    mfa_pkg::result_t r;
    start     <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_item(it, r);
    if (mfa_pkg::op_e'(it.op) == mfa_pkg::OP_READ) begin
      pending_reads = {pending_reads, (typed ? typed_res : r)};
    end
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Wait until the block is idle and every read has returned
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || pending_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == mfa_pkg::CFG_THRESHOLD) thr_reg = data;
    else cnt_reg = data[12:0];
    @(posedge clk_i);
  endtask

  function automatic mfa_pkg::item_t mk(mfa_pkg::op_e op, int idx, logic [15:0] x,
                                        logic [15:0] y, logic [15:0] z, logic [31:0] r2);
    mfa_pkg::item_t it;
    it.op = op; it.vertex_index = idx[11:0];
    it.pos_x = x; it.pos_y = y; it.pos_z = z; it.radius_sq = r2;
    return it;
  endfunction

  task automatic add_row(mfa_pkg::item_t it, bit typed = 1'b0, mfa_pkg::result_t res = '0);
    row_t rw;
    rw.itm = it; rw.typed = typed; rw.res = res;
    dir_rows = {dir_rows, rw};
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'(32'h7FFF - $urandom_range(0, 3));
      2:       return 16'(32'h8000 + $urandom_range(0, 3));
      default: return 16'($signed($urandom_range(0, 127)) - 64);
    endcase
  endfunction

  function automatic logic [31:0] rand_r2();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 32'h0010_0000);
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // One random item; adds are only made when every walked position is known
  task automatic random_item(bit no_add);
    mfa_pkg::item_t it;
    int             idx, miss;
    int             pick;
    pick = $urandom_range(0, 99);
    idx  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                        : $urandom_range(0, SMALL_SET - 1);
    if (pick < 30) begin
      it = mk(mfa_pkg::OP_WRITE, idx, rand_coord(), rand_coord(), rand_coord(), $urandom());
    end else if (pick < 35) begin
      it = mk(mfa_pkg::OP_CLEAR, $urandom(), 16'($urandom()), 16'($urandom()),
              16'($urandom()), $urandom());
    end else if (pick < 65) begin
      it = mk(mfa_pkg::OP_ADD, $urandom(), rand_coord(), rand_coord(), rand_coord(),
              rand_r2());
    end else begin
      it = mk(mfa_pkg::OP_READ, idx, 16'($urandom()), 16'($urandom()),
              16'($urandom()), $urandom());
    end
    if (mfa_pkg::op_e'(it.op) == mfa_pkg::OP_ADD) begin
      miss = -1;
      for (int j = int'(cnt_reg) - 1; j >= 0; j--) if (!pos_known[j]) miss = j;
      if (no_add) it.op = mfa_pkg::OP_READ;
      else if (miss >= 0) begin
        it.op = mfa_pkg::OP_WRITE;
        it.vertex_index = miss[11:0];
      end
    end
    issue_item(it, 1'b0, '0);
  endtask

  initial begin
    mfa_pkg::result_t zr;
    int               thr_set [5];
    int               cnt_set [5];
    allow_idle  = 1'b1;
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mfa_pkg::CFG_THRESHOLD;
    cfg_data_i  = '0;
    thr_reg     = mfa_pkg::THRESHOLD_RESET;
    cnt_reg     = mfa_pkg::COUNT_RESET;
    clear_shadow();
    for (int j = 0; j < mfa_pkg::GRID_VERTICES; j++) pos_known[j] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, walked with a small vertex set
    zr = '0;
    add_row(mk(mfa_pkg::OP_READ, 0, '0, '0, '0, '0), 1'b1, zr);
    zr.out_index = 12'hFFF;
    add_row(mk(mfa_pkg::OP_READ, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1, zr);
    add_row(mk(mfa_pkg::OP_WRITE, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0));
    add_row(mk(mfa_pkg::OP_WRITE, 1, 16'h8000, 16'h8000, 16'h8000, '0));
    add_row(mk(mfa_pkg::OP_WRITE, 2, 16'h0000, 16'h0000, 16'h0000, '0));
    add_row(mk(mfa_pkg::OP_WRITE, 3, 16'h0010, 16'h0020, 16'hFFF0, '0));
    add_row(mk(mfa_pkg::OP_WRITE, 4095, 16'h1234, 16'hA5A5, 16'h5A5A, 32'hFFFF_FFFF));
    // ball centered on vertex 2: that vertex is skipped
    add_row(mk(mfa_pkg::OP_ADD, 0, '0, '0, '0, 32'h0001_0000));
    zr.out_index = 12'd2;
    add_row(mk(mfa_pkg::OP_READ, 2, '0, '0, '0, '0), 1'b1, zr);
    add_row(mk(mfa_pkg::OP_READ, 0, '0, '0, '0, '0));
    add_row(mk(mfa_pkg::OP_READ, 1, '0, '0, '0, '0));
    add_row(mk(mfa_pkg::OP_READ, 3, '0, '0, '0, '0));
    // saturating balls at the corners and next to vertex 2, then a zero-radius ball next to vertex 3
    add_row(mk(mfa_pkg::OP_ADD, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF));
    add_row(mk(mfa_pkg::OP_ADD, 0, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF));
    add_row(mk(mfa_pkg::OP_ADD, 0, 16'h0000, 16'h0000, 16'h0001, 32'hFFFF_FFFF));
    add_row(mk(mfa_pkg::OP_ADD, 0, 16'h0000, 16'h0000, 16'h0001, 32'hFFFF_FFFF));
    add_row(mk(mfa_pkg::OP_ADD, 0, 16'h0011, 16'h0020, 16'hFFF0, 32'h0000_0000));
    for (int j = 0; j < 4; j++) add_row(mk(mfa_pkg::OP_READ, j, '0, '0, '0, '0));
    add_row(mk(mfa_pkg::OP_CLEAR, 0, '0, '0, '0, '0));
    zr.out_index = 12'd3;
    add_row(mk(mfa_pkg::OP_READ, 3, '0, '0, '0, '0), 1'b1, zr);
    add_row(mk(mfa_pkg::OP_ADD, 0, 16'h0010, 16'h0020, 16'hFFF1, 32'h0000_0001));
    add_row(mk(mfa_pkg::OP_READ, 3, '0, '0, '0, '0));
    add_row(mk(mfa_pkg::OP_READ, 4095, '0, '0, '0, '0));

    drain();
    write_reg(mfa_pkg::CFG_COUNT, 32'd4);
    foreach (dir_rows[i]) issue_item(dir_rows[i].itm, dir_rows[i].typed, dir_rows[i].res);

    // Random phases under several settings; full-grid count has no adds
    thr_set = '{0, 32'hFFFF_FFFF, 100, 1966, 1};
    cnt_set = '{8, 16, 4096, 1, 12};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(mfa_pkg::CFG_THRESHOLD, thr_set[ph]);
      write_reg(mfa_pkg::CFG_COUNT, cnt_set[ph]);
      if (ph == 4) allow_idle = 1'b0;
      repeat (24) random_item(cnt_set[ph] > SMALL_SET);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
